[rtl/sbwm_pkg.sv]
// Shared constants for the SPI bus word monitor: phase codes, register map, reset values.
package sbwm_pkg;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BITS_PER_WORD      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MSB_FIRST          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLOCK_IDLE_HIGH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_ON_TRAILING = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_ACTIVE_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_USE_ENABLE         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MOSI_USED          = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MISO_USED          = 3'd7;

    // Register reset values
    localparam logic [CFG_DATA_W-1:0] RST_BITS_PER_WORD = 7'd8;
    localparam logic RST_MSB_FIRST          = 1'b1;
    localparam logic RST_CLOCK_IDLE_HIGH    = 1'b0;
    localparam logic RST_SAMPLE_ON_TRAILING = 1'b0;
    localparam logic RST_ENABLE_ACTIVE_HIGH = 1'b0;
    localparam logic RST_USE_ENABLE         = 1'b1;
    localparam logic RST_MOSI_USED          = 1'b1;
    localparam logic RST_MISO_USED          = 1'b1;

    // Bus phase codes
    localparam int PHASE_W = 2;
    localparam logic [PHASE_W-1:0] PH_WAIT   = 2'd0;
    localparam logic [PHASE_W-1:0] PH_POLERR = 2'd1;
    localparam logic [PHASE_W-1:0] PH_IDLE   = 2'd2;
    localparam logic [PHASE_W-1:0] PH_ACTIVE = 2'd3;

    // Result kinds
    localparam logic KIND_WORD   = 1'b0;
    localparam logic KIND_POLERR = 1'b1;

    localparam int INDEX_W = 16;

endpackage

[rtl/spi_bus_word_monitor_unit.sv]
// Passive SPI bus monitor: deserializes MOSI/MISO words from sampled bus lines.
//
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+---------------------------------------------
//  s_       | in  | s_valid / s_ready   | clock, mosi, miso, enable line samples
//  m_       | out | m_valid / m_ready   | kind, mosi/miso words, index, start/end tick
//  cfg_     | in  | cfg_we (no wait)    | cfg_index selects register, cfg_wdata
//
//  One sample is taken per cycle while s_ready is high; its result (zero or
//  one item) lands in the output register at the same edge and shows on m_ the next cycle.
//  s_ready is high whenever the output register is empty or is being drained,
//  so a stalled m_ side holds the input only while a result is still waiting.
//  Reset (aresetn low, synchronous) clears the bus phase, counters and the
//  tick counter, and loads the register defaults.
module spi_bus_word_monitor_unit #(
    parameter int MAX_WORD_BITS = 64,
    parameter int TICK_BITS     = 48
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           cfg_we,
    input  logic [sbwm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sbwm_pkg::CFG_DATA_W-1:0] cfg_wdata,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_clock_level,
    input  logic                           s_mosi_level,
    input  logic                           s_miso_level,
    input  logic                           s_enable_level,

    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_kind,
    output logic [MAX_WORD_BITS-1:0]       m_mosi_data,
    output logic [MAX_WORD_BITS-1:0]       m_miso_data,
    output logic [sbwm_pkg::INDEX_W-1:0]   m_word_index,
    output logic [TICK_BITS-1:0]           m_start_tick,
    output logic [TICK_BITS-1:0]           m_end_tick
);
    import sbwm_pkg::*;

    localparam int BCW  = $clog2(MAX_WORD_BITS + 1);
    localparam int IDXW = $clog2(MAX_WORD_BITS);

    // Configuration registers
    logic [CFG_DATA_W-1:0] bits_per_word_reg;
    logic msb_first_reg, clock_idle_high_reg, sample_on_trailing_reg;
    logic enable_active_high_reg, use_enable_reg, mosi_used_reg, miso_used_reg;

    // Bus tracking state
    logic [TICK_BITS-1:0]     tick_reg, tick_next;
    logic                     prev_enable_reg;
    logic [PHASE_W-1:0]       phase_reg, phase_next;
    logic [BCW-1:0]           bit_count_reg, bit_count_next;
    logic [MAX_WORD_BITS-1:0] mosi_shift_reg, mosi_shift_next;
    logic [MAX_WORD_BITS-1:0] miso_shift_reg, miso_shift_next;
    logic [INDEX_W-1:0]       word_count_reg, word_count_next;
    logic [TICK_BITS-1:0]     word_start_reg, word_start_next;
    logic [TICK_BITS-1:0]     last_edge_reg, last_edge_next;

    // Output register
    logic                     m_valid_reg, m_valid_next;
    logic                     m_kind_reg;
    logic [MAX_WORD_BITS-1:0] m_mosi_reg, m_miso_reg;
    logic [INDEX_W-1:0]       m_index_reg;
    logic [TICK_BITS-1:0]     m_start_reg, m_end_reg;

    // Result of this sample
    logic                     res_fire;
    logic                     res_kind;
    logic [MAX_WORD_BITS-1:0] res_mosi, res_miso;
    logic [INDEX_W-1:0]       res_index;
    logic [TICK_BITS-1:0]     res_start, res_end;

    logic s_fire;
    logic act, pact, clk_idle;
    logic [BCW-1:0]           eff_bits;
    logic [MAX_WORD_BITS-1:0] word_mask;
    logic                     take_ok;
    logic [MAX_WORD_BITS-1:0] take_mosi, take_miso;
    logic [BCW-1:0]           take_count;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bits_per_word_reg      <= RST_BITS_PER_WORD;
            msb_first_reg          <= RST_MSB_FIRST;
            clock_idle_high_reg    <= RST_CLOCK_IDLE_HIGH;
            sample_on_trailing_reg <= RST_SAMPLE_ON_TRAILING;
            enable_active_high_reg <= RST_ENABLE_ACTIVE_HIGH;
            use_enable_reg         <= RST_USE_ENABLE;
            mosi_used_reg          <= RST_MOSI_USED;
            miso_used_reg          <= RST_MISO_USED;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_BITS_PER_WORD:      bits_per_word_reg      <= cfg_wdata;
                REG_MSB_FIRST:          msb_first_reg          <= cfg_wdata[0];
                REG_CLOCK_IDLE_HIGH:    clock_idle_high_reg    <= cfg_wdata[0];
                REG_SAMPLE_ON_TRAILING: sample_on_trailing_reg <= cfg_wdata[0];
                REG_ENABLE_ACTIVE_HIGH: enable_active_high_reg <= cfg_wdata[0];
                REG_USE_ENABLE:         use_enable_reg         <= cfg_wdata[0];
                REG_MOSI_USED:          mosi_used_reg          <= cfg_wdata[0];
                REG_MISO_USED:          miso_used_reg          <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Saturate word length to 1..MAX_WORD_BITS
    always_comb begin
        if (bits_per_word_reg == '0) begin
            eff_bits = BCW'(1);
        end else if (bits_per_word_reg > CFG_DATA_W'(MAX_WORD_BITS)) begin
            eff_bits = BCW'(MAX_WORD_BITS);
        end else begin
            eff_bits = BCW'(bits_per_word_reg);
        end
    end

    assign word_mask = {MAX_WORD_BITS{1'b1}} >> (BCW'(MAX_WORD_BITS) - eff_bits);

    // Shift in one bit pair; stop once the word is full
    assign take_ok = bit_count_reg < eff_bits;

    always_comb begin
        take_mosi  = mosi_shift_reg;
        take_miso  = miso_shift_reg;
        take_count = bit_count_reg;
        if (take_ok) begin
            if (msb_first_reg) begin
                take_mosi = {mosi_shift_reg[MAX_WORD_BITS-2:0], s_mosi_level};
                take_miso = {miso_shift_reg[MAX_WORD_BITS-2:0], s_miso_level};
            end else begin
                take_mosi = mosi_shift_reg
                    | (MAX_WORD_BITS'(s_mosi_level) << bit_count_reg[IDXW-1:0]);
                take_miso = miso_shift_reg
                    | (MAX_WORD_BITS'(s_miso_level) << bit_count_reg[IDXW-1:0]);
            end
            take_count = bit_count_reg + BCW'(1);
        end
    end

    assign act      = use_enable_reg ? (s_enable_level == enable_active_high_reg) : 1'b1;
    assign pact     = use_enable_reg ? (prev_enable_reg == enable_active_high_reg) : 1'b1;
    assign clk_idle = (s_clock_level == clock_idle_high_reg);

    // Bus phase tracking and word framing
    always_comb begin
        phase_next      = phase_reg;
        bit_count_next  = bit_count_reg;
        mosi_shift_next = mosi_shift_reg;
        miso_shift_next = miso_shift_reg;
        word_count_next = word_count_reg;
        word_start_next = word_start_reg;
        last_edge_next  = last_edge_reg;
        tick_next       = tick_reg + TICK_BITS'(1);

        res_fire  = 1'b0;
        res_kind  = KIND_WORD;
        res_mosi  = mosi_used_reg ? (mosi_shift_reg & word_mask) : '0;
        res_miso  = miso_used_reg ? (miso_shift_reg & word_mask) : '0;
        res_index = word_count_reg;
        res_start = word_start_reg;
        res_end   = last_edge_reg;

        unique case (phase_reg)
            PH_WAIT: begin
                if (use_enable_reg) begin
                    if (act && !pact) begin
                        bit_count_next  = '0;
                        mosi_shift_next = '0;
                        miso_shift_next = '0;
                        word_count_next = '0;
                        if (clk_idle) begin
                            phase_next = PH_IDLE;
                        end else begin
                            word_start_next = tick_reg;
                            phase_next      = PH_POLERR;
                        end
                    end
                end else if (clk_idle) begin
                    bit_count_next  = '0;
                    mosi_shift_next = '0;
                    miso_shift_next = '0;
                    phase_next      = PH_IDLE;
                end
            end
            PH_POLERR: begin
                if (!use_enable_reg) begin
                    // drop the pending error
                    phase_next = PH_WAIT;
                end else if (!act) begin
                    res_fire   = 1'b1;
                    res_kind   = KIND_POLERR;
                    res_mosi   = '0;
                    res_miso   = '0;
                    res_index  = '0;
                    res_end    = tick_reg;
                    phase_next = PH_WAIT;
                end
            end
            PH_IDLE: begin
                if (!act) begin
                    bit_count_next  = '0;
                    mosi_shift_next = '0;
                    miso_shift_next = '0;
                    phase_next      = PH_WAIT;
                end else if (!clk_idle) begin
                    // leading edge
                    if (bit_count_reg == '0) begin
                        word_start_next = tick_reg;
                    end
                    last_edge_next = tick_reg;
                    if (!sample_on_trailing_reg) begin
                        bit_count_next  = take_count;
                        mosi_shift_next = take_mosi;
                        miso_shift_next = take_miso;
                    end
                    phase_next = PH_ACTIVE;
                end
            end
            PH_ACTIVE: begin
                if (!act) begin
                    // release wins over a same-tick edge; a full leading-edge word survives
                    if (!sample_on_trailing_reg && (bit_count_reg >= eff_bits)) begin
                        res_fire        = 1'b1;
                        word_count_next = word_count_reg + INDEX_W'(1);
                    end
                    bit_count_next  = '0;
                    mosi_shift_next = '0;
                    miso_shift_next = '0;
                    phase_next      = PH_WAIT;
                end else if (clk_idle) begin
                    // trailing edge
                    last_edge_next = tick_reg;
                    if (sample_on_trailing_reg) begin
                        bit_count_next  = take_count;
                        mosi_shift_next = take_mosi;
                        miso_shift_next = take_miso;
                        res_mosi = mosi_used_reg ? (take_mosi & word_mask) : '0;
                        res_miso = miso_used_reg ? (take_miso & word_mask) : '0;
                    end
                    if (bit_count_next >= eff_bits) begin
                        res_fire        = 1'b1;
                        res_end         = tick_reg;
                        word_count_next = word_count_reg + INDEX_W'(1);
                        bit_count_next  = '0;
                        mosi_shift_next = '0;
                        miso_shift_next = '0;
                    end
                    phase_next = PH_IDLE;
                end
            end
            default: begin
                bit_count_next  = '0;
                mosi_shift_next = '0;
                miso_shift_next = '0;
                phase_next      = PH_WAIT;
            end
        endcase
    end

    // Advance bus state on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg        <= '0;
            prev_enable_reg <= 1'b0;
            phase_reg       <= PH_WAIT;
            bit_count_reg   <= '0;
            mosi_shift_reg  <= '0;
            miso_shift_reg  <= '0;
            word_count_reg  <= '0;
            word_start_reg  <= '0;
            last_edge_reg   <= '0;
        end else if (s_fire) begin
            tick_reg        <= tick_next;
            prev_enable_reg <= s_enable_level;
            phase_reg       <= phase_next;
            bit_count_reg   <= bit_count_next;
            mosi_shift_reg  <= mosi_shift_next;
            miso_shift_reg  <= miso_shift_next;
            word_count_reg  <= word_count_next;
            word_start_reg  <= word_start_next;
            last_edge_reg   <= last_edge_next;
        end
    end

    // Output register: load a new result, otherwise hold until taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_fire) begin
            m_valid_next = res_fire;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && res_fire) begin
            m_kind_reg  <= res_kind;
            m_mosi_reg  <= res_mosi;
            m_miso_reg  <= res_miso;
            m_index_reg <= res_index;
            m_start_reg <= res_start;
            m_end_reg   <= res_end;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_kind       = m_kind_reg;
    assign m_mosi_data  = m_mosi_reg;
    assign m_miso_data  = m_miso_reg;
    assign m_word_index = m_index_reg;
    assign m_start_tick = m_start_reg;
    assign m_end_tick   = m_end_reg;

    // Checks
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_kind_reg == KIND_POLERR)) |->
            (m_mosi_reg == '0) && (m_miso_reg == '0) && (m_index_reg == '0))
        else $error("error frame carries nonzero word data");

    assert property (@(posedge aclk) disable iff (!aresetn)
        bit_count_reg <= BCW'(MAX_WORD_BITS))
        else $error("bit count beyond word capacity");

    assert property (@(posedge aclk) disable iff (!aresetn)
        ((phase_reg == PH_WAIT) || (phase_reg == PH_POLERR)) |-> (bit_count_reg == '0))
        else $error("partial word held outside a transfer");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_kind_reg == KIND_WORD)) |->
            (word_count_reg == m_index_reg + INDEX_W'(1)))
        else $error("word counter out of step with emitted index");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && s_valid && s_ready) |=> (tick_reg == $past(tick_reg) + TICK_BITS'(1)))
        else $error("tick counter did not advance on accepted item");

endmodule

[bench/spi_bus_word_monitor_unit_test.sv]
// Self-checking bench for the SPI bus word monitor: stimulus, word prediction, scoreboard.
module spi_bus_word_monitor_unit_test;

    import sbwm_pkg::*;

    localparam int WORD_MAX = 64;

    // One result item as the block presents it on the m_ side
    typedef struct packed {
        logic        kind;
        logic [63:0] mosi;
        logic [63:0] miso;
        logic [15:0] index;
        logic [47:0] t_start;
        logic [47:0] t_end;
    } spi_word_t;

    // One full set of register values
    typedef struct {
        int bits;
        bit msb;
        bit idle_hi;
        bit trail;
        bit en_hi;
        bit use_en;
        bit mosi_on;
        bit miso_on;
    } bus_setting_t;

    // Word predictor plus the queue of words it has promised
    class spi_word_scoreboard;
        bit [6:0]    bits_cfg;
        bit          msb_first, idle_high, trailing, en_high, use_en, mosi_on, miso_on;
        bit [47:0]   tick;
        bit          prev_en;
        logic [1:0]  ph;
        int          nbits;
        bit [63:0]   mosi_sr, miso_sr;
        bit [15:0]   word_no;
        bit [47:0]   first_tick, edge_tick;
        spi_word_t   pending[$];
        int          n_expected;
        int          n_errors;

        function new();
            bits_cfg = RST_BITS_PER_WORD;
            msb_first = RST_MSB_FIRST;
            idle_high = RST_CLOCK_IDLE_HIGH;
            trailing = RST_SAMPLE_ON_TRAILING;
            en_high = RST_ENABLE_ACTIVE_HIGH;
            use_en = RST_USE_ENABLE;
            mosi_on = RST_MOSI_USED;
            miso_on = RST_MISO_USED;
            tick = '0;
            prev_en = 1'b0;
            ph = PH_WAIT;
            drop_word();
            word_no = '0;
            first_tick = '0;
            edge_tick = '0;
            n_expected = 0;
            n_errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_BITS_PER_WORD:      bits_cfg = val;
                REG_MSB_FIRST:          msb_first = val[0];
                REG_CLOCK_IDLE_HIGH:    idle_high = val[0];
                REG_SAMPLE_ON_TRAILING: trailing = val[0];
                REG_ENABLE_ACTIVE_HIGH: en_high = val[0];
                REG_USE_ENABLE:         use_en = val[0];
                REG_MOSI_USED:          mosi_on = val[0];
                REG_MISO_USED:          miso_on = val[0];
                default: ;
            endcase
        endfunction

        // Saturate the programmed length to 1..WORD_MAX
        function int word_len();
            int b;
            b = int'(bits_cfg);
            if (b < 1) b = 1;
            if (b > WORD_MAX) b = WORD_MAX;
            return b;
        endfunction

        function void drop_word();
            mosi_sr = '0;
            miso_sr = '0;
            nbits = 0;
        endfunction

        function void shift_in(bit mo, bit mi);
            if (nbits >= word_len()) return;
            if (msb_first) begin
                mosi_sr = {mosi_sr[62:0], mo};
                miso_sr = {miso_sr[62:0], mi};
            end else begin
                mosi_sr = mosi_sr | (64'(mo) << nbits);
                miso_sr = miso_sr | (64'(mi) << nbits);
            end
            nbits++;
        endfunction

        function void push_result(logic kind, bit [63:0] mo, bit [63:0] mi, bit [15:0] idx,
                                  bit [47:0] t0, bit [47:0] t1);
            spi_word_t w;
            w.kind = kind;
            w.mosi = mo;
            w.miso = mi;
            w.index = idx;
            w.t_start = t0;
            w.t_end = t1;
            pending = {pending, w};
            n_expected++;
        endfunction

        function void emit_word(bit [47:0] t_end);
            bit [63:0] mask;
            mask = {64{1'b1}} >> (WORD_MAX - word_len());
            push_result(KIND_WORD, mosi_on ? (mosi_sr & mask) : 64'd0,
                        miso_on ? (miso_sr & mask) : 64'd0, word_no, first_tick, t_end);
            word_no++;
            drop_word();
        endfunction

        // Advance the bus tracker by one accepted line sample
        function void note_sample(bit c, bit mo, bit mi, bit en);
            bit act, pact, idle;
            act = use_en ? (en == en_high) : 1'b1;
            pact = use_en ? (prev_en == en_high) : 1'b1;
            idle = (c == idle_high);
            case (ph)
                PH_WAIT: begin
                    if (use_en) begin
                        if (act && !pact) begin
                            drop_word();
                            word_no = '0;
                            if (idle) begin
                                ph = PH_IDLE;
                            end else begin
                                first_tick = tick;
                                ph = PH_POLERR;
                            end
                        end
                    end else if (idle) begin
                        drop_word();
                        ph = PH_IDLE;
                    end
                end
                PH_POLERR: begin
                    if (!use_en) begin
                        ph = PH_WAIT;
                    end else if (!act) begin
                        push_result(KIND_POLERR, '0, '0, '0, first_tick, tick);
                        ph = PH_WAIT;
                    end
                end
                PH_IDLE: begin
                    if (!act) begin
                        drop_word();
                        ph = PH_WAIT;
                    end else if (!idle) begin
                        if (nbits == 0) first_tick = tick;
                        edge_tick = tick;
                        if (!trailing) shift_in(mo, mi);
                        ph = PH_ACTIVE;
                    end
                end
                PH_ACTIVE: begin
                    if (!act) begin
                        if (!trailing && nbits >= word_len()) emit_word(edge_tick);
                        drop_word();
                        ph = PH_WAIT;
                    end else if (idle) begin
                        edge_tick = tick;
                        if (trailing) shift_in(mo, mi);
                        if (nbits >= word_len()) emit_word(tick);
                        ph = PH_IDLE;
                    end
                end
                default: begin
                    drop_word();
                    ph = PH_WAIT;
                end
            endcase
            prev_en = en;
            tick++;
        endfunction

        function void compare_field(string name, bit [63:0] want, bit [63:0] got);
            if (want === got) return;
            n_errors++;
            if (n_errors <= 10)
                $display("mismatch on %s: expected %0h, got %0h", name, want, got);
        endfunction

        function void check_result(spi_word_t got);
            spi_word_t want;
            if (pending.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result: kind %0h mosi %0h miso %0h index %0h",
                             got.kind, got.mosi, got.miso, got.index);
                return;
            end
            want = pending.pop_front();
            compare_field("kind", 64'(want.kind), 64'(got.kind));
            compare_field("mosi_data", want.mosi, got.mosi);
            compare_field("miso_data", want.miso, got.miso);
            compare_field("word_index", 64'(want.index), 64'(got.index));
            compare_field("start_tick", 64'(want.t_start), 64'(got.t_start));
            compare_field("end_tick", 64'(want.t_end), 64'(got.t_end));
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic                   s_clock_level = 1'b0;
    logic                   s_mosi_level = 1'b0;
    logic                   s_miso_level = 1'b0;
    logic                   s_enable_level = 1'b0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic                   m_kind;
    logic [63:0]            m_mosi_data;
    logic [63:0]            m_miso_data;
    logic [INDEX_W-1:0]     m_word_index;
    logic [47:0]            m_start_tick;
    logic [47:0]            m_end_tick;

    spi_word_scoreboard sb;
    bus_setting_t       cur;
    int                 n_items = 0;
    int                 tx_gap_odds = 4;  // one sample in this many starts a gap; 0 is none
    bit                 rx_idle = 1'b1;
    bit                 hold_req = 1'b0;

    spi_bus_word_monitor_unit DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_clock_level  (s_clock_level),
        .s_mosi_level   (s_mosi_level),
        .s_miso_level   (s_miso_level),
        .s_enable_level (s_enable_level),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_mosi_data    (m_mosi_data),
        .m_miso_data    (m_miso_data),
        .m_word_index   (m_word_index),
        .m_start_tick   (m_start_tick),
        .m_end_tick     (m_end_tick)
    );

    always #5 aclk = ~aclk;

    function automatic bit coin();
        return 1'($urandom_range(0, 1));
    endfunction

    // Offer one line sample and hold it until the block takes it. Handshake
    // signals are read right after the edge, so they still show the values
    // that decided acceptance at that edge.
    task automatic push_sample(bit c, bit mo, bit mi, bit en);
        if (tx_gap_odds != 0 && $urandom_range(1, tx_gap_odds) == 1) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_clock_level <= c;
        s_mosi_level <= mo;
        s_miso_level <= mi;
        s_enable_level <= en;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_sample(c, mo, mi, en);
        n_items++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        sb.set_reg(idx, val);
        @(posedge aclk);
    endtask

    // Program every register; only call while the block is idle
    task automatic apply_setting(bus_setting_t s);
        cur = s;
        write_reg(REG_BITS_PER_WORD, 7'(s.bits));
        write_reg(REG_MSB_FIRST, 7'(s.msb));
        write_reg(REG_CLOCK_IDLE_HIGH, 7'(s.idle_hi));
        write_reg(REG_SAMPLE_ON_TRAILING, 7'(s.trail));
        write_reg(REG_ENABLE_ACTIVE_HIGH, 7'(s.en_hi));
        write_reg(REG_USE_ENABLE, 7'(s.use_en));
        write_reg(REG_MOSI_USED, 7'(s.mosi_on));
        write_reg(REG_MISO_USED, 7'(s.miso_on));
        cfg_we <= 1'b0;
    endtask

    // Drop valid, drain every promised word, then let the pipe run dry
    task automatic settle();
        s_valid <= 1'b0;
        for (int k = 0; k < 2000 && sb.pending.size() != 0; k++) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // One chip-select framed packet: mostly whole words with random data,
    // sometimes a polarity fault, a release mid-word, or plain line noise.
    task automatic run_packet();
        bit idl, act;
        int style, eff, total, cut;
        idl = cur.idle_hi;
        act = cur.en_hi;
        eff = (cur.bits < 1) ? 1 : (cur.bits > WORD_MAX) ? WORD_MAX : cur.bits;
        style = $urandom_range(0, 19);
        repeat ($urandom_range(1, 2)) push_sample(idl, coin(), coin(), !act);
        if (style == 0) begin
            // assert with the clock away from idle, release later
            push_sample(!idl, coin(), coin(), act);
            repeat ($urandom_range(0, 3)) push_sample(coin(), coin(), coin(), act);
            push_sample(coin(), coin(), coin(), !act);
        end else if (style == 1) begin
            repeat ($urandom_range(3, 10)) push_sample(coin(), coin(), coin(), coin());
        end else begin
            total = eff * ((eff > 16) ? 1 : $urandom_range(1, 3));
            cut = ($urandom_range(0, 5) == 0) ? $urandom_range(0, total - 1) : total;
            push_sample(idl, coin(), coin(), act);
            for (int b = 0; b < cut; b++) begin
                repeat (($urandom_range(0, 3) == 0) ? 2 : 1)
                    push_sample(!idl, coin(), coin(), act);
                // leading-edge mode: release before the last trailing edge
                if (b == total - 1 && !cur.trail && $urandom_range(0, 2) == 0) begin
                    cut = -1;
                    break;
                end
                repeat (($urandom_range(0, 3) == 0) ? 2 : 1)
                    push_sample(idl, coin(), coin(), act);
            end
            if (cut < 0)
                push_sample(!idl, coin(), coin(), !act);
            else if (cut < total)
                push_sample(coin(), coin(), coin(), !act);
            else
                push_sample(idl, coin(), coin(), !act);
        end
    endtask

    // Free-running clock: enable line toggles at random and must be ignored
    task automatic run_free(int count);
        int start;
        bit c;
        start = n_items;
        c = cur.idle_hi;
        while (n_items - start < count) begin
            repeat ($urandom_range(1, 2)) push_sample(c, coin(), coin(), coin());
            c = !c;
            if ($urandom_range(0, 11) == 0) push_sample(coin(), coin(), coin(), coin());
        end
    endtask

    // Force the length extremes in the first phases, then draw at random
    function automatic bus_setting_t pick_setting(int n);
        bus_setting_t s;
        int r;
        r = $urandom_range(0, 19);
        s.bits = (r == 0) ? 64 : (r == 1) ? 127 : (r == 2) ? 0 :
                 (r < 10) ? $urandom_range(1, 4) : $urandom_range(5, 12);
        if (n == 0) s.bits = 64;
        else if (n == 1) s.bits = 127;
        else if (n == 2) s.bits = 0;
        else if (n == 3) s.bits = 1;
        s.msb = coin();
        s.idle_hi = coin();
        s.trail = coin();
        s.en_hi = coin();
        s.use_en = ($urandom_range(0, 3) != 0);
        s.mosi_on = ($urandom_range(0, 4) != 0);
        s.miso_on = ($urandom_range(0, 4) != 0);
        return s;
    endfunction

    // Result side: check every accepted item, then pick the next ready level.
    // Stalls come in short bursts; one long hold-off is requested by the main
    // sequence to back the block up into its input.
    initial begin
        spi_word_t got;
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (m_valid === 1'b1 && m_ready === 1'b1) begin
                got.kind = m_kind;
                got.mosi = m_mosi_data;
                got.miso = m_miso_data;
                got.index = m_word_index;
                got.t_start = m_start_tick;
                got.t_end = m_end_tick;
                sb.check_result(got);
            end
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (rx_idle && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 15) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Main sequence
    initial begin
        int phase_no;
        int budget;
        int start;
        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: two-bit words, MSB first, idle-low clock, leading edge,
        // active-low enable.
        apply_setting('{2, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1});
        // enable already active out of reset: no packet, the edge is ignored
        push_sample(0, 1, 1, 0);
        push_sample(1, 1, 1, 0);
        push_sample(0, 0, 0, 1);
        // assert with the clock high, release: polarity error
        push_sample(1, 0, 0, 0);
        push_sample(1, 1, 0, 1);
        // full word, released before its final trailing edge: still emitted
        push_sample(0, 0, 0, 0);
        push_sample(1, 1, 0, 0);
        push_sample(0, 0, 0, 0);
        push_sample(1, 0, 1, 0);
        push_sample(1, 0, 0, 1);
        // release mid-word together with an edge: partial word dropped
        push_sample(0, 0, 0, 0);
        push_sample(1, 1, 1, 0);
        push_sample(0, 0, 0, 1);
        // leave a polarity error pending
        push_sample(1, 0, 0, 0);
        settle();

        // Free-running mode abandons the pending error; take two of three bits
        apply_setting('{3, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1});
        push_sample(1, 1, 1, 1);
        push_sample(1, 0, 0, 0);
        push_sample(0, 1, 1, 1);
        push_sample(1, 1, 0, 0);
        push_sample(0, 0, 1, 1);
        push_sample(1, 0, 1, 0);
        push_sample(0, 1, 0, 1);
        settle();

        // Shorten the word below the bits taken: emitted at the next trailing edge
        apply_setting('{1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1});
        push_sample(1, 1, 1, 0);
        settle();

        // Long receiver hold-off with one-bit words and no input gaps: the
        // output register fills and the input stalls behind it
        apply_setting('{1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1});
        tx_gap_odds = 0;
        hold_req = 1'b1;
        run_free(60);

        // Random phases: new setting each phase, until enough samples
        phase_no = 0;
        while (n_items < 900) begin
            settle();
            apply_setting(pick_setting(phase_no));
            if (n_items >= 600) begin
                // tail of the run: no idling on either side, finish in one phase
                tx_gap_odds = 0;
                rx_idle = 1'b0;
                budget = 900 - n_items;
            end else begin
                tx_gap_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 12);
                rx_idle = ($urandom_range(0, 3) != 0);
                budget = (cur.bits > 16) ? 150 : $urandom_range(50, 120);
                if (budget > 600 - n_items) budget = 600 - n_items;
            end
            start = n_items;
            if (cur.use_en) begin
                while (n_items - start < budget) run_packet();
            end else begin
                run_free(budget);
            end
            phase_no++;
        end

        settle();
        if (sb.pending.size() != 0) begin
            sb.n_errors++;
            $display("%0d expected results never arrived", sb.pending.size());
        end
        if (sb.n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
